/* sv/binned_transfer_curve_accumulator_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the binned transfer curve accumulator
// Each macro is one clocked concurrent assertion, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef BINNED_TRANSFER_CURVE_ACCUMULATOR_DEFINES_SVH
`define BINNED_TRANSFER_CURVE_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication
`define BTCA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("btca check failed");

// Next-cycle implication
`define BTCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("btca check failed");

`endif

/* sv/btca_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btca_pkg
// Shared types and fixed constants of the binned transfer curve accumulator.
// ----------------------------------------------------------------------------
package btca_pkg;

    // Field widths of the item and result words
    localparam int MODE_W    = 2;
    localparam int FIELD_W   = 16;
    localparam int SELECT_W  = 8;
    localparam int IDX_W     = 8;
    localparam int CNT_W     = 32;
    localparam int SUM_W     = 48;
    localparam int MEAN_W    = 16;

    // Configuration register
    localparam int NUM_BINS_W                = 9;
    localparam logic [NUM_BINS_W-1:0] NUM_BINS_RST = 9'd256;
    localparam int APB_ADDR_W                = 3;
    localparam int APB_DATA_W                = 32;
    localparam logic [0:0] REG_NUM_BINS      = 1'b0;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Mode codes on the input word
    localparam logic [MODE_W-1:0] MODE_ACC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // Operation after classification
    typedef enum logic [1:0] {
        OP_ACC,
        OP_READ,
        OP_CLEAR
    } t_op;

    // Back end sequencer states
    typedef enum logic [2:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_LOOK,
        BS_DIV,
        BS_EMIT
    } t_bstate;

    // Flow control seen by the front end
    typedef struct packed {
        logic q_full;
        logic clearing;
    } t_front_ctl;

endpackage

/* sv/binned_transfer_curve_accumulator.sv */
// Path: an accepted word is queued, popped with its bin RAM read, looked up in LOOK
//   and handed over in EMIT; a read whose mean needs the 16-step divider also passes BS_DIV.
// Flow: the back end works on one word at a time, reading then writing the bin RAM,
//   and pops the next word as EMIT hands over a result; a mean division holds it in BS_DIV.
// Reset: the bin store is zeroed one entry a cycle with the input stalled;
//   num_bins returns to 256.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binned_transfer_curve_accumulator
// Conditional mean histogram: sums and counts output samples per input bin,
// with read and read-and-clear of a bin's count, sum and mean.
// ----------------------------------------------------------------------------
module binned_transfer_curve_accumulator #(
    parameter int MAX_BINS    = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [btca_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [btca_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [btca_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [btca_pkg::MODE_W-1:0]            i_mode,
    input  logic signed [btca_pkg::FIELD_W-1:0]    i_sample_in,
    input  logic signed [btca_pkg::FIELD_W-1:0]    i_sample_out,
    input  logic [btca_pkg::SELECT_W-1:0]          i_bin_select,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [btca_pkg::IDX_W-1:0]             o_bin_index,
    output logic [btca_pkg::CNT_W-1:0]             o_bin_count,
    output logic signed [btca_pkg::SUM_W-1:0]      o_bin_sum,
    output logic signed [btca_pkg::MEAN_W-1:0]     o_bin_mean,
    output logic                                   o_bin_empty,
    output logic                                   o_sample_dropped
);

    localparam int NB_W   = $clog2(MAX_BINS + 1);
    localparam int BIN_W  = $clog2(MAX_BINS);
    localparam int NBR_W  = btca_pkg::NUM_BINS_W;
    localparam int CMP_W  = (NB_W > NBR_W) ? NB_W : NBR_W;
    localparam int OP_W   = $bits(btca_pkg::t_op);
    localparam int IDX_W  = btca_pkg::IDX_W;
    localparam int RAM_W  = btca_pkg::CNT_W + btca_pkg::SUM_W;
    localparam int ITEM_W = OP_W + BIN_W + 1 + IDX_W + SAMPLE_BITS;

    logic [NBR_W-1:0] r_num_bins;
    logic [CMP_W-1:0] nb_wide;
    logic [CMP_W-1:0] nb_clamp;
    logic [NB_W-1:0]  nb;
    logic             reg_hit;

    btca_pkg::t_front_ctl front_ctl;
    logic                 push;
    btca_pkg::t_op        f_op;
    logic [BIN_W-1:0]     f_addr;
    logic                 f_in_range;
    logic [IDX_W-1:0]     f_index;
    logic [SAMPLE_BITS-1:0] f_sample;
    logic [ITEM_W-1:0]    push_data;

    logic                 q_valid;
    logic                 q_full;
    logic                 q_pop;
    logic [ITEM_W-1:0]    q_data;

    logic                 ram_rd_en;
    logic [BIN_W-1:0]     ram_rd_addr;
    logic [RAM_W-1:0]     ram_rd_data;
    logic                 ram_wr_en;
    logic [BIN_W-1:0]     ram_wr_addr;
    logic [RAM_W-1:0]     ram_wr_data;
    logic                 clearing;

    // Configuration register
    assign pready  = 1'b1;
    assign reg_hit = (paddr[btca_pkg::APB_ADDR_W-1:2] == btca_pkg::REG_NUM_BINS);
    assign prdata  = reg_hit ? btca_pkg::APB_DATA_W'(r_num_bins) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_bins <= btca_pkg::NUM_BINS_RST;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_num_bins <= pwdata[NBR_W-1:0];
        end
    end

    // Clamp the bin count into 1 to MAX_BINS
    assign nb_wide  = CMP_W'(r_num_bins);
    assign nb_clamp = (nb_wide == '0) ? CMP_W'(1)
                    : ((nb_wide > CMP_W'(MAX_BINS)) ? CMP_W'(MAX_BINS) : nb_wide);
    assign nb       = nb_clamp[NB_W-1:0];

    assign front_ctl.q_full   = q_full;
    assign front_ctl.clearing = clearing;

    btca_front #(
        .MAX_BINS    (MAX_BINS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_in_valid   (i_in_valid),
        .i_mode       (i_mode),
        .i_sample_in  (i_sample_in),
        .i_sample_out (i_sample_out),
        .i_bin_select (i_bin_select),
        .i_nb         (nb),
        .i_ctl        (front_ctl),
        .o_in_stall   (o_in_stall),
        .o_push       (push),
        .o_op         (f_op),
        .o_addr       (f_addr),
        .o_in_range   (f_in_range),
        .o_index      (f_index),
        .o_sample     (f_sample)
    );

    // Pack the classified word for the queue
    assign push_data = {f_op, f_addr, f_in_range, f_index, f_sample};

    btca_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (btca_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_data)
    );

    btca_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_BINS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    btca_back #(
        .MAX_BINS    (MAX_BINS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_op           (btca_pkg::t_op'(q_data[ITEM_W-1 -: OP_W])),
        .i_q_addr         (q_data[ITEM_W-OP_W-1 -: BIN_W]),
        .i_q_in_range     (q_data[IDX_W + SAMPLE_BITS]),
        .i_q_index        (q_data[SAMPLE_BITS +: IDX_W]),
        .i_q_sample       (q_data[SAMPLE_BITS-1:0]),
        .o_q_pop          (q_pop),
        .o_ram_rd_en      (ram_rd_en),
        .o_ram_rd_addr    (ram_rd_addr),
        .i_ram_rd_data    (ram_rd_data),
        .o_ram_wr_en      (ram_wr_en),
        .o_ram_wr_addr    (ram_wr_addr),
        .o_ram_wr_data    (ram_wr_data),
        .o_clearing       (clearing),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_bin_index      (o_bin_index),
        .o_bin_count      (o_bin_count),
        .o_bin_sum        (o_bin_sum),
        .o_bin_mean       (o_bin_mean),
        .o_bin_empty      (o_bin_empty),
        .o_sample_dropped (o_sample_dropped)
    );

endmodule

/* sv/btca_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btca_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module btca_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/btca_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btca_queue
// Short register queue that decouples the classifier from the bin updater.
// ----------------------------------------------------------------------------
module btca_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_data  = r_mem[r_rd_ptr];

endmodule

/* sv/btca_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btca_front
// Accept input words, decode the mode and map the input sample to its bin.
// ----------------------------------------------------------------------------
module btca_front #(
    parameter int MAX_BINS    = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_in_valid,
    input  logic [btca_pkg::MODE_W-1:0]         i_mode,
    input  logic signed [btca_pkg::FIELD_W-1:0] i_sample_in,
    input  logic signed [btca_pkg::FIELD_W-1:0] i_sample_out,
    input  logic [btca_pkg::SELECT_W-1:0]       i_bin_select,
    input  logic [$clog2(MAX_BINS+1)-1:0]       i_nb,
    input  btca_pkg::t_front_ctl                i_ctl,
    output logic                                o_in_stall,
    output logic                                o_push,
    output btca_pkg::t_op                       o_op,
    output logic [$clog2(MAX_BINS)-1:0]         o_addr,
    output logic                                o_in_range,
    output logic [btca_pkg::IDX_W-1:0]          o_index,
    output logic [SAMPLE_BITS-1:0]              o_sample
);

    localparam int NB_W  = $clog2(MAX_BINS + 1);
    localparam int BIN_W = $clog2(MAX_BINS);
    localparam int SB    = SAMPLE_BITS;
    localparam int PAD_W = 40;

    logic [PAD_W-1:0]   in_z;
    logic [PAD_W-1:0]   out_z;
    logic [SB-1:0]      x_s;
    logic [SB-1:0]      x_off;
    logic [SB+NB_W-1:0] prod;
    logic [NB_W-1:0]    b_raw;
    logic [NB_W-1:0]    nb_m1;
    logic [NB_W-1:0]    b_acc;
    logic [31:0]        b_z;
    logic [31:0]        sel_z;

    // Stall while the queue is full or the store is being cleared
    assign o_in_stall = i_ctl.q_full | i_ctl.clearing;
    assign o_push     = i_in_valid & ~o_in_stall;

    // Take the low sample bits of each field
    assign in_z  = {{(PAD_W - btca_pkg::FIELD_W){1'b0}}, i_sample_in};
    assign out_z = {{(PAD_W - btca_pkg::FIELD_W){1'b0}}, i_sample_out};
    assign x_s   = in_z[SB-1:0];
    assign o_sample = out_z[SB-1:0];

    // Bin = ((x + half range) * nb) >> SB, clamped to nb-1
    assign x_off = {~x_s[SB-1], x_s[SB-2:0]};
    assign prod  = (SB+NB_W)'(x_off) * (SB+NB_W)'(i_nb);
    assign b_raw = prod[SB +: NB_W];
    assign nb_m1 = i_nb - NB_W'(1);
    assign b_acc = (b_raw > nb_m1) ? nb_m1 : b_raw;
    assign b_z   = 32'(b_acc);
    assign sel_z = 32'(i_bin_select);

    // Classify the word
    always_comb begin
        case (i_mode)
            btca_pkg::MODE_ACC: begin
                o_op       = btca_pkg::OP_ACC;
                o_addr     = b_z[BIN_W-1:0];
                o_in_range = 1'b1;
                o_index    = b_z[btca_pkg::IDX_W-1:0];
            end
            btca_pkg::MODE_CLEAR: begin
                o_op       = btca_pkg::OP_CLEAR;
                o_addr     = sel_z[BIN_W-1:0];
                o_in_range = (sel_z < 32'(MAX_BINS));
                o_index    = i_bin_select;
            end
            default: begin
                o_op       = btca_pkg::OP_READ;
                o_addr     = sel_z[BIN_W-1:0];
                o_in_range = (sel_z < 32'(MAX_BINS));
                o_index    = i_bin_select;
            end
        endcase
    end

endmodule

/* sv/btca_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btca_back
// Clear the bin store after reset, update or read bins, divide for the mean
// and hold the result word until it is taken.
// ----------------------------------------------------------------------------
module btca_back #(
    parameter int MAX_BINS    = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    input  btca_pkg::t_op                       i_q_op,
    input  logic [$clog2(MAX_BINS)-1:0]         i_q_addr,
    input  logic                                i_q_in_range,
    input  logic [btca_pkg::IDX_W-1:0]          i_q_index,
    input  logic [SAMPLE_BITS-1:0]              i_q_sample,
    output logic                                o_q_pop,
    output logic                                o_ram_rd_en,
    output logic [$clog2(MAX_BINS)-1:0]         o_ram_rd_addr,
    input  logic [btca_pkg::CNT_W+btca_pkg::SUM_W-1:0] i_ram_rd_data,
    output logic                                o_ram_wr_en,
    output logic [$clog2(MAX_BINS)-1:0]         o_ram_wr_addr,
    output logic [btca_pkg::CNT_W+btca_pkg::SUM_W-1:0] o_ram_wr_data,
    output logic                                o_clearing,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [btca_pkg::IDX_W-1:0]          o_bin_index,
    output logic [btca_pkg::CNT_W-1:0]          o_bin_count,
    output logic signed [btca_pkg::SUM_W-1:0]   o_bin_sum,
    output logic signed [btca_pkg::MEAN_W-1:0]  o_bin_mean,
    output logic                                o_bin_empty,
    output logic                                o_sample_dropped
);

    localparam int BIN_W = $clog2(MAX_BINS);
    localparam int SB    = SAMPLE_BITS;
    localparam int CW    = btca_pkg::CNT_W;
    localparam int SW    = btca_pkg::SUM_W;
    localparam int MW    = btca_pkg::MEAN_W;
    localparam int QW    = btca_pkg::MEAN_W;
    localparam int DW    = $clog2(QW);

    localparam logic [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic [MW-1:0] MEAN_MAX = {1'b0, {(MW-1){1'b1}}};
    localparam logic [MW-1:0] MEAN_MIN = {1'b1, {(MW-1){1'b0}}};

    btca_pkg::t_bstate r_state, n_state;

    // Item being worked on
    btca_pkg::t_op   r_op,       n_op;
    logic [BIN_W-1:0] r_addr,    n_addr;
    logic            r_in_range, n_in_range;
    logic [btca_pkg::IDX_W-1:0] r_index, n_index;
    logic [SB-1:0]   r_sample,   n_sample;

    // Result held for the output register
    logic [CW-1:0]   r_res_cnt,  n_res_cnt;
    logic [SW-1:0]   r_res_sum,  n_res_sum;
    logic [MW-1:0]   r_res_mean, n_res_mean;
    logic            r_res_empty, n_res_empty;
    logic            r_res_drop, n_res_drop;

    // Divider
    logic [QW-1:0]   r_mag_lo,   n_mag_lo;
    logic [CW-1:0]   r_rem,      n_rem;
    logic [QW-1:0]   r_quo,      n_quo;
    logic [DW-1:0]   r_div_cnt,  n_div_cnt;
    logic            r_neg,      n_neg;

    // Clearing pass
    logic [BIN_W-1:0] r_clr_addr, n_clr_addr;

    // Output register
    logic            r_out_valid, n_out_valid;
    logic [btca_pkg::IDX_W-1:0] r_out_index;
    logic [CW-1:0]   r_out_cnt;
    logic [SW-1:0]   r_out_sum;
    logic [MW-1:0]   r_out_mean;
    logic            r_out_empty;
    logic            r_out_drop;
    logic            out_load;

    // Lookup datapath
    logic [CW-1:0]   look_cnt;
    logic [SW-1:0]   look_sum;
    logic [SW:0]     acc_sum;
    logic [SW-1:0]   acc_sat;
    logic [SW-1:0]   look_mag;
    logic [CW-1:0]   look_hi;

    // Divider step
    logic [CW:0]     div_shift;
    logic            div_ge;
    logic [CW:0]     div_diff;
    logic [QW-1:0]   div_quo;
    logic [MW-1:0]   div_mean;

    // Bin contents, forced empty for a select beyond the store
    assign look_cnt = r_in_range ? i_ram_rd_data[SW +: CW] : '0;
    assign look_sum = r_in_range ? i_ram_rd_data[SW-1:0]   : '0;

    // Saturating sum update
    assign acc_sum = {look_sum[SW-1], look_sum}
                   + {{(SW+1-SB){r_sample[SB-1]}}, r_sample};
    assign acc_sat = (acc_sum[SW] != acc_sum[SW-1])
                   ? (acc_sum[SW] ? SUM_MIN : SUM_MAX) : acc_sum[SW-1:0];

    // Magnitude of the sum and its upper part for the overflow test
    assign look_mag = look_sum[SW-1] ? (~look_sum + SW'(1)) : look_sum;
    assign look_hi  = look_mag[SW-1:QW];

    // One restoring division step
    assign div_shift = {r_rem, r_mag_lo[r_div_cnt]};
    assign div_ge    = (div_shift >= {1'b0, r_res_cnt});
    assign div_diff  = div_shift - {1'b0, r_res_cnt};
    assign div_quo   = {r_quo[QW-2:0], div_ge};
    assign div_mean  = r_neg ? ((div_quo > MEAN_MIN) ? MEAN_MIN : (~div_quo + MW'(1)))
                             : (div_quo[QW-1] ? MEAN_MAX : div_quo);

    assign out_load = ~r_out_valid | ~i_out_stall;

    // Next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_addr      = r_addr;
        n_in_range  = r_in_range;
        n_index     = r_index;
        n_sample    = r_sample;
        n_res_cnt   = r_res_cnt;
        n_res_sum   = r_res_sum;
        n_res_mean  = r_res_mean;
        n_res_empty = r_res_empty;
        n_res_drop  = r_res_drop;
        n_mag_lo    = r_mag_lo;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_div_cnt   = r_div_cnt;
        n_neg       = r_neg;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid & i_out_stall;
        o_q_pop       = 1'b0;
        o_ram_wr_en   = 1'b0;
        o_ram_wr_addr = r_addr;
        o_ram_wr_data = '0;

        case (r_state)
            btca_pkg::BS_CLEAR: begin
                // Zero one entry a cycle
                o_ram_wr_en   = 1'b1;
                o_ram_wr_addr = r_clr_addr;
                n_clr_addr    = r_clr_addr + BIN_W'(1);
                if (r_clr_addr == BIN_W'(MAX_BINS - 1)) begin
                    n_state = btca_pkg::BS_IDLE;
                end
            end
            btca_pkg::BS_IDLE: begin
                o_q_pop = i_q_valid;
                if (i_q_valid) begin
                    n_state = btca_pkg::BS_LOOK;
                end
            end
            btca_pkg::BS_LOOK: begin
                n_res_cnt   = look_cnt;
                n_res_sum   = look_sum;
                n_res_mean  = '0;
                n_res_empty = 1'b0;
                n_res_drop  = 1'b0;
                n_state     = btca_pkg::BS_EMIT;
                if (r_op == btca_pkg::OP_ACC) begin
                    // Drop the sample once the count is saturated
                    if (look_cnt == '1) begin
                        n_res_drop = 1'b1;
                    end else begin
                        n_res_cnt     = look_cnt + CW'(1);
                        n_res_sum     = acc_sat;
                        o_ram_wr_en   = 1'b1;
                        o_ram_wr_data = {look_cnt + CW'(1), acc_sat};
                    end
                end else begin
                    n_res_empty = (look_cnt == '0);
                    if ((r_op == btca_pkg::OP_CLEAR) && r_in_range) begin
                        o_ram_wr_en = 1'b1;
                    end
                    n_neg    = look_sum[SW-1];
                    n_mag_lo = look_mag[QW-1:0];
                    n_rem    = look_hi;
                    n_quo    = '0;
                    n_div_cnt = DW'(QW - 1);
                    if (look_cnt != '0) begin
                        if (look_hi >= look_cnt) begin
                            // Quotient beyond the mean range
                            n_res_mean = look_sum[SW-1] ? MEAN_MIN : MEAN_MAX;
                        end else begin
                            n_state = btca_pkg::BS_DIV;
                        end
                    end
                end
            end
            btca_pkg::BS_DIV: begin
                n_rem     = div_ge ? div_diff[CW-1:0] : div_shift[CW-1:0];
                n_quo     = div_quo;
                n_div_cnt = r_div_cnt - DW'(1);
                if (r_div_cnt == '0) begin
                    n_res_mean = div_mean;
                    n_state    = btca_pkg::BS_EMIT;
                end
            end
            btca_pkg::BS_EMIT: begin
                // Hand over the result, then start the next word
                if (out_load) begin
                    n_out_valid = 1'b1;
                    o_q_pop     = i_q_valid;
                    n_state     = i_q_valid ? btca_pkg::BS_LOOK : btca_pkg::BS_IDLE;
                end
            end
            default: begin
                n_state = btca_pkg::BS_IDLE;
            end
        endcase

        if (o_q_pop) begin
            n_op       = i_q_op;
            n_addr     = i_q_addr;
            n_in_range = i_q_in_range;
            n_index    = i_q_index;
            n_sample   = i_q_sample;
        end
    end

    assign o_ram_rd_en   = o_q_pop;
    assign o_ram_rd_addr = i_q_addr;
    assign o_clearing    = (r_state == btca_pkg::BS_CLEAR);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= btca_pkg::BS_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_addr      <= n_addr;
        r_in_range  <= n_in_range;
        r_index     <= n_index;
        r_sample    <= n_sample;
        r_res_cnt   <= n_res_cnt;
        r_res_sum   <= n_res_sum;
        r_res_mean  <= n_res_mean;
        r_res_empty <= n_res_empty;
        r_res_drop  <= n_res_drop;
        r_mag_lo    <= n_mag_lo;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_div_cnt   <= n_div_cnt;
        r_neg       <= n_neg;
        if ((r_state == btca_pkg::BS_EMIT) && out_load) begin
            r_out_index <= r_index;
            r_out_cnt   <= r_res_cnt;
            r_out_sum   <= r_res_sum;
            r_out_mean  <= r_res_mean;
            r_out_empty <= r_res_empty;
            r_out_drop  <= r_res_drop;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_bin_index      = r_out_index;
    assign o_bin_count      = r_out_cnt;
    assign o_bin_sum        = r_out_sum;
    assign o_bin_mean       = r_out_mean;
    assign o_bin_empty      = r_out_empty;
    assign o_sample_dropped = r_out_drop;

endmodule

/* sv/btca_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btca_checker
// Port-level checks of the accumulator result words, bound to the top level.
// ----------------------------------------------------------------------------
`include "binned_transfer_curve_accumulator_defines.svh"

module btca_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic [btca_pkg::IDX_W-1:0]         o_bin_index,
    input logic [btca_pkg::CNT_W-1:0]         o_bin_count,
    input logic signed [btca_pkg::SUM_W-1:0]  o_bin_sum,
    input logic signed [btca_pkg::MEAN_W-1:0] o_bin_mean,
    input logic                               o_bin_empty,
    input logic                               o_sample_dropped
);

    // Hold a stalled result word: valid, index, count and sum stay
    `BTCA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_bin_index) && $stable(o_bin_count) && $stable(o_bin_sum))

    // A dropped sample only comes from a saturated count
    `BTCA_ASSERT_SAME(a_drop_sat, i_clk, i_rst_n, o_out_valid && o_sample_dropped, (o_bin_count == 32'hFFFF_FFFF) && (o_bin_mean == 16'sd0) && !o_bin_empty)

    // An empty bin has no sum and no mean
    `BTCA_ASSERT_SAME(a_empty_bin, i_clk, i_rst_n, o_out_valid && (o_bin_count == 32'd0), o_bin_empty && (o_bin_mean == 16'sd0) && (o_bin_sum == 48'sd0))

    // A negative mean comes from a negative sum
    `BTCA_ASSERT_SAME(a_mean_sign, i_clk, i_rst_n, o_out_valid && o_bin_mean[15], o_bin_sum[47] && !o_bin_empty)

endmodule

bind binned_transfer_curve_accumulator btca_checker u_btca_checker (.*);

/* tb/binned_transfer_curve_accumulator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binned_transfer_curve_accumulator_tb
// Drives accumulate, read and read-and-clear words through the accumulator
// under several bin settings and random flow control, and compares every
// result word against an in-bench copy of the bin store.
// ----------------------------------------------------------------------------
module binned_transfer_curve_accumulator_tb;

    localparam int MODE_W       = btca_pkg::MODE_W;
    localparam int FIELD_W      = btca_pkg::FIELD_W;
    localparam int SELECT_W     = btca_pkg::SELECT_W;
    localparam int IDX_W        = btca_pkg::IDX_W;
    localparam int CNT_W        = btca_pkg::CNT_W;
    localparam int SUM_W        = btca_pkg::SUM_W;
    localparam int MEAN_W       = btca_pkg::MEAN_W;
    localparam int NUM_BINS_W   = btca_pkg::NUM_BINS_W;
    localparam int APB_ADDR_W   = btca_pkg::APB_ADDR_W;
    localparam int APB_DATA_W   = btca_pkg::APB_DATA_W;

    localparam int BINS_MAX     = 256;
    localparam int SAMPLE_W     = 16;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_WORDS  = 70;
    localparam int HOLD_AFTER   = 250;
    localparam int HOLD_CYCLES  = 400;

    // Mode codes that the package leaves unnamed
    localparam logic [MODE_W-1:0] MODE_READ     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ_ALT = 2'd3;

    localparam logic [APB_ADDR_W-1:0] ADDR_NUM_BINS =
        APB_ADDR_W'({btca_pkg::REG_NUM_BINS, 2'b00});

    localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_LO = -SUM_HI - 1;

    typedef struct {
        logic [IDX_W-1:0]         idx;
        logic [CNT_W-1:0]         cnt;
        logic signed [SUM_W-1:0]  sum;
        logic signed [MEAN_W-1:0] mean;
        logic                     empty;
        logic                     dropped;
    } t_bin_result;

    // ------------------------------------------------------------------------
    // Bin store copy and queue of expected result words
    // ------------------------------------------------------------------------
    class bin_histogram_board;
        logic signed [SUM_W-1:0] sums [BINS_MAX];
        logic [CNT_W-1:0]        counts [BINS_MAX];
        logic [NUM_BINS_W-1:0]   num_bins;
        t_bin_result             pending_bins [$];
        int                      last_bin;
        int n_acc, n_read, n_clear, n_checked, n_errors, n_configs;

        function new();
            foreach (sums[i]) begin
                sums[i]   = '0;
                counts[i] = '0;
            end
            num_bins  = btca_pkg::NUM_BINS_RST;
            last_bin  = 0;
            n_acc     = 0;
            n_read    = 0;
            n_clear   = 0;
            n_checked = 0;
            n_errors  = 0;
            n_configs = 0;
        endfunction

        function void set_num_bins(logic [NUM_BINS_W-1:0] nb);
            num_bins = nb;
            n_configs++;
        endfunction

        // Clamp the register to the bins that exist
        function int used_bins();
            if (num_bins == 0) return 1;
            if (num_bins > BINS_MAX) return BINS_MAX;
            return int'(num_bins);
        endfunction

        function int pending();
            return pending_bins.size();
        endfunction

        // Update the store for one accepted word and queue its result
        function void take_word(logic [MODE_W-1:0] m, logic signed [SAMPLE_W-1:0] x,
                                logic signed [SAMPLE_W-1:0] y, logic [SELECT_W-1:0] sel);
            t_bin_result r;
            int          nb;
            int          b;
            longint      offs;
            longint      s;
            longint      q;
            r.mean    = '0;
            r.empty   = 1'b0;
            r.dropped = 1'b0;
            if (m == btca_pkg::MODE_ACC) begin
                n_acc++;
                nb   = used_bins();
                offs = longint'(x) + (longint'(1) << (SAMPLE_W - 1));
                b    = int'((offs * nb) >>> SAMPLE_W);
                if (b > nb - 1) b = nb - 1;
                // drop the sample when the count is already at its ceiling
                if (counts[b] == '1) begin
                    r.dropped = 1'b1;
                end else begin
                    s = longint'(sums[b]) + longint'(y);
                    if (s > SUM_HI) s = SUM_HI;
                    if (s < SUM_LO) s = SUM_LO;
                    sums[b] = s[SUM_W-1:0];
                    counts[b]++;
                end
                last_bin = b;
                r.idx    = b[IDX_W-1:0];
                r.cnt    = counts[b];
                r.sum    = sums[b];
            end else begin
                if (m == btca_pkg::MODE_CLEAR) n_clear++;
                else n_read++;
                r.idx = sel;
                r.cnt = '0;
                r.sum = '0;
                if (int'(sel) < BINS_MAX) begin
                    r.cnt = counts[sel];
                    r.sum = sums[sel];
                    if (m == btca_pkg::MODE_CLEAR) begin
                        counts[sel] = '0;
                        sums[sel]   = '0;
                    end
                end
                r.empty = (r.cnt == 0);
                if (r.cnt != 0) begin
                    q = longint'(r.sum) / longint'({32'b0, r.cnt});
                    if (q > 32767) q = 32767;
                    if (q < -32768) q = -32768;
                    r.mean = q[MEAN_W-1:0];
                end
            end
            pending_bins.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
            if (exp_v !== got_v) begin
                n_errors++;
                $display("%0t: %0s mismatch, expected %0h, actual %0h",
                         $time, name, exp_v, got_v);
            end
        endfunction

        // Compare one result word with the oldest expectation
        function void match_bin_result(t_bin_result got);
            t_bin_result want;
            n_checked++;
            if (pending_bins.size() == 0) begin
                n_errors++;
                $display("%0t: result word with none expected, expected nothing, actual bin %0d",
                         $time, got.idx);
                return;
            end
            want = pending_bins.pop_front();
            compare_field("bin_index", 64'(want.idx), 64'(got.idx));
            compare_field("bin_count", 64'(want.cnt), 64'(got.cnt));
            compare_field("bin_sum", 64'(want.sum), 64'(got.sum));
            compare_field("bin_mean", 64'(want.mean), 64'(got.mean));
            compare_field("bin_empty", 64'(want.empty), 64'(got.empty));
            compare_field("sample_dropped", 64'(want.dropped), 64'(got.dropped));
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [APB_ADDR_W-1:0]         paddr;
    logic [APB_DATA_W-1:0]         pwdata;
    logic [APB_DATA_W-1:0]         prdata;
    logic                          pready;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic [MODE_W-1:0]             i_mode;
    logic signed [FIELD_W-1:0]     i_sample_in;
    logic signed [FIELD_W-1:0]     i_sample_out;
    logic [SELECT_W-1:0]           i_bin_select;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic [IDX_W-1:0]              o_bin_index;
    logic [CNT_W-1:0]              o_bin_count;
    logic signed [SUM_W-1:0]       o_bin_sum;
    logic signed [MEAN_W-1:0]      o_bin_mean;
    logic                          o_bin_empty;
    logic                          o_sample_dropped;

    int                 cycle_count;
    bin_histogram_board sb = new();

    binned_transfer_curve_accumulator #(
        .MAX_BINS    (BINS_MAX),
        .SAMPLE_BITS (SAMPLE_W)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_mode           (i_mode),
        .i_sample_in      (i_sample_in),
        .i_sample_out     (i_sample_out),
        .i_bin_select     (i_bin_select),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_bin_index      (o_bin_index),
        .o_bin_count      (o_bin_count),
        .o_bin_sum        (o_bin_sum),
        .o_bin_mean       (o_bin_mean),
        .o_bin_empty      (o_bin_empty),
        .o_sample_dropped (o_sample_dropped)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Give up on a hung run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("Some tests failed");
        $finish;
    end

    // Check every result word taken by the receiver
    always @(posedge i_clk) begin
        t_bin_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.idx     = o_bin_index;
            got.cnt     = o_bin_count;
            got.sum     = o_bin_sum;
            got.mean    = o_bin_mean;
            got.empty   = o_bin_empty;
            got.dropped = o_sample_dropped;
            sb.match_bin_result(got);
        end
    end

    // Receiver: stall on a pattern of its own, with one long hold-off
    initial begin : receiver
        int seg_len;
        int style;
        int k;
        bit hold_done;
        i_out_stall = 1'b0;
        hold_done   = 1'b0;
        forever begin
            if (!hold_done && sb.n_checked >= HOLD_AFTER) begin
                hold_done = 1'b1;
                for (k = 0; k < HOLD_CYCLES; k++) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end else begin
                style   = $urandom_range(0, 3);
                seg_len = $urandom_range(4, 40);
                for (k = 0; k < seg_len; k++) begin
                    @(negedge i_clk);
                    case (style)
                        0: i_out_stall <= 1'b0;
                        1: i_out_stall <= 1'($urandom_range(0, 1));
                        2: i_out_stall <= ($urandom_range(0, 9) < 8);
                        default: i_out_stall <= (k < 6);
                    endcase
                end
            end
        end
    end

    // Offer one word and hold it until accepted
    task automatic send_word(input logic [MODE_W-1:0] m, input logic signed [FIELD_W-1:0] x,
                             input logic signed [FIELD_W-1:0] y,
                             input logic [SELECT_W-1:0] sel);
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_mode       <= m;
        i_sample_in  <= x;
        i_sample_out <= y;
        i_bin_select <= sel;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.take_word(m, x, y, sel);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    // Pause the sender until every expected word is back, then let the block settle
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_num_bins(input logic [NUM_BINS_W-1:0] nb);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_NUM_BINS;
        pwdata  <= APB_DATA_W'(nb);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_num_bins(nb);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Favor full-scale, zero and minus-one samples now and then
    function automatic logic signed [FIELD_W-1:0] pick_sample();
        case ($urandom_range(0, 11))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return FIELD_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_random_word();
        int                  r;
        logic [MODE_W-1:0]   m;
        logic [SELECT_W-1:0] sel;
        r = $urandom_range(0, 99);
        if (r < 72) m = btca_pkg::MODE_ACC;
        else if (r < 86) m = MODE_READ;
        else if (r < 96) m = btca_pkg::MODE_CLEAR;
        else m = MODE_READ_ALT;
        // mostly read bins that hold data
        r = $urandom_range(0, 9);
        if (r < 5) sel = SELECT_W'(sb.last_bin);
        else if (r < 8) sel = SELECT_W'($urandom_range(0, sb.used_bins() - 1));
        else sel = SELECT_W'($urandom_range(0, 255));
        send_word(m, pick_sample(), pick_sample(), sel);
    endtask

    // Random bursts with random gaps, then drain
    task automatic run_random_phase(input int words);
        int sent;
        int burst;
        int gap;
        int k;
        sent = 0;
        while (sent < words) begin
            burst = $urandom_range(1, 24);
            for (k = 0; k < burst && sent < words; k++) begin
                send_random_word();
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) idle_cycles(gap);
        end
        drain_results();
    endtask

    // Extremes, every mode, empty and cleared bins, bin-count clamping
    task automatic run_directed();
        write_num_bins(9'd256);
        send_word(btca_pkg::MODE_ACC, 16'sh8000, 16'sh7FFF, 8'd0);
        send_word(btca_pkg::MODE_ACC, 16'sh8000, 16'sh7FFF, 8'd0);
        send_word(btca_pkg::MODE_ACC, 16'sh7FFF, 16'sh8000, 8'd0);
        send_word(btca_pkg::MODE_ACC, 16'sd0, -16'sd3, 8'd0);
        send_word(btca_pkg::MODE_ACC, 16'sd1, -16'sd4, 8'd0);
        send_word(btca_pkg::MODE_ACC, -16'sd1, 16'sd0, 8'd0);
        send_word(MODE_READ, 16'sd0, 16'sd0, 8'd0);
        send_word(MODE_READ, 16'sd0, 16'sd0, 8'd255);
        send_word(MODE_READ_ALT, 16'sd0, 16'sd0, 8'd128);
        send_word(MODE_READ, 16'sd0, 16'sd0, 8'd127);
        send_word(btca_pkg::MODE_CLEAR, 16'sd0, 16'sd0, 8'd0);
        send_word(MODE_READ, 16'sd0, 16'sd0, 8'd0);
        send_word(MODE_READ, 16'sd0, 16'sd0, 8'd200);
        send_word(btca_pkg::MODE_CLEAR, 16'sd0, 16'sd0, 8'd200);
        drain_results();
        // zero bins acts as one
        write_num_bins(9'd0);
        send_word(btca_pkg::MODE_ACC, 16'sh7FFF, 16'sd5, 8'd0);
        send_word(btca_pkg::MODE_ACC, 16'sh8000, -16'sd5, 8'd0);
        send_word(MODE_READ, 16'sd0, 16'sd0, 8'd0);
        send_word(MODE_READ, 16'sd0, 16'sd0, 8'd255);
        drain_results();
        // above the store size clamps to all bins
        write_num_bins(9'd511);
        send_word(btca_pkg::MODE_ACC, 16'sh7FFF, 16'sd100, 8'd0);
        send_word(btca_pkg::MODE_ACC, 16'sh8000, 16'sd100, 8'd0);
        send_word(btca_pkg::MODE_CLEAR, 16'sd0, 16'sd0, 8'd255);
        drain_results();
        // bin edges with an odd bin count
        write_num_bins(9'd3);
        send_word(btca_pkg::MODE_ACC, 16'sd21845, 16'sd9, 8'd0);
        send_word(btca_pkg::MODE_ACC, -16'sd10923, 16'sd9, 8'd0);
        send_word(btca_pkg::MODE_ACC, -16'sd10922, -16'sd9, 8'd0);
        send_word(MODE_READ, 16'sd0, 16'sd0, 8'd1);
        drain_results();
    endtask

    initial begin : stimulus
        logic [NUM_BINS_W-1:0] phase_bins [8];
        int p;
        phase_bins = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd7, 9'd64, 9'd300, 9'd2};
        phase_bins[7] = NUM_BINS_W'($urandom_range(2, 255));

        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        i_in_valid   = 1'b0;
        i_mode       = btca_pkg::MODE_ACC;
        i_sample_in  = '0;
        i_sample_out = '0;
        i_bin_select = '0;

        // Hold reset, then release it
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        for (p = 0; p < 8; p++) begin
            write_num_bins(phase_bins[p]);
            run_random_phase(PHASE_WORDS);
        end

        // Wait out stragglers, then report
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.n_errors++;
            $display("%0t: %0d result words never arrived, expected 0, actual %0d",
                     $time, sb.pending(), sb.pending());
        end

        $display("Run covered %0d result words: %0d accumulates, %0d reads, %0d read-and-clears",
                 sb.n_checked, sb.n_acc, sb.n_read, sb.n_clear);
        $display("Bin count was set %0d times, including 0, 1, 256 and 511", sb.n_configs);
        if (sb.n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
